[sv/footprint_grid_collision_check_defines.svh]
// ============================================================================
// Footprint grid collision check: assertion macros
// Short forms for the concurrent checks kept at the end of the RTL module.
// ============================================================================
`ifndef FOOTPRINT_GRID_COLLISION_CHECK_DEFINES_SVH
`define FOOTPRINT_GRID_COLLISION_CHECK_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define FGCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define FGCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/fgcc_pkg.sv]
// ============================================================================
// fgcc_pkg
// Constants and codes shared by the footprint grid collision check.
// ============================================================================
package fgcc_pkg;

    // Default sizes handed to the top level parameters.
    localparam int MAP_CELLS_DEF       = 65536;
    localparam int SQRT_ITERATIONS_DEF = 16;

    // A cell value at or above this limit is occupied.
    localparam logic signed [7:0] OCCUPIED_LIMIT = 8'sd50;

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    // Result cause codes.
    localparam logic [1:0] CAUSE_CLEAR    = 2'd0;
    localparam logic [1:0] CAUSE_OCCUPIED = 2'd1;
    localparam logic [1:0] CAUSE_OUTSIDE  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_LENGTH   = 3'd0;
    localparam logic [2:0] REG_WIDTH    = 3'd1;
    localparam logic [2:0] REG_ORIGIN_X = 3'd2;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd3;
    localparam logic [2:0] REG_CPM      = 3'd4;
    localparam logic [2:0] REG_COLUMNS  = 3'd5;
    localparam logic [2:0] REG_ROWS     = 3'd6;

endpackage

[sv/footprint_grid_collision_check.sv]
// ============================================================================
// footprint_grid_collision_check
// Checks a rectangular robot footprint at a given pose against a stored
// occupancy grid held in one synchronous memory.
// ============================================================================
// A cell write (cmd 0) and a pose check issued before any cell was written
// leave busy low; an unloaded check gives its clear result on o_valid in the
// next cycle. A loaded pose check holds busy high until its four corners are
// checked, ending early at the first corner that is outside or occupied. It
// uses one shared 34 x 34 multiplier stepped through the products of each
// corner, the bit-serial square root of one step per cycle, and the map
// memory's one read port with a registered read. Each result shows on o_hit
// and o_hit_cause with o_valid high for exactly one cycle; the receiver must
// take it then. The configuration port is always ready and must only be
// written while busy is low and no result is pending.
module footprint_grid_collision_check #(
    parameter int MAP_CELLS       = fgcc_pkg::MAP_CELLS_DEF,
    parameter int SQRT_ITERATIONS = fgcc_pkg::SQRT_ITERATIONS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cmd,
    input  logic [15:0]        i_cell_index,
    input  logic signed [7:0]  i_cell_value,
    input  logic signed [23:0] i_pose_x,
    input  logic signed [23:0] i_pose_y,
    input  logic signed [15:0] i_orient_z,
    output logic               o_valid,
    output logic               o_hit,
    output logic [1:0]         o_hit_cause,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    `include "footprint_grid_collision_check_defines.svh"

    localparam int AW  = $clog2(MAP_CELLS);
    localparam int SQ  = SQRT_ITERATIONS;
    localparam int RW  = 2 * SQ;
    localparam int SHR = 64 - 2 * SQ;
    localparam int CW  = $clog2(SQ);

    // Sequencer states.
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_ZZ   = 5'd1;
    localparam logic [4:0] ST_SQI  = 5'd2;
    localparam logic [4:0] ST_SQ   = 5'd3;
    localparam logic [4:0] ST_SIN  = 5'd4;
    localparam logic [4:0] ST_PA   = 5'd5;
    localparam logic [4:0] ST_PB   = 5'd6;
    localparam logic [4:0] ST_PC   = 5'd7;
    localparam logic [4:0] ST_PD   = 5'd8;
    localparam logic [4:0] ST_PE   = 5'd9;
    localparam logic [4:0] ST_CRN  = 5'd10;
    localparam logic [4:0] ST_LX   = 5'd11;
    localparam logic [4:0] ST_HX   = 5'd12;
    localparam logic [4:0] ST_FX   = 5'd13;
    localparam logic [4:0] ST_HY   = 5'd14;
    localparam logic [4:0] ST_FY   = 5'd15;
    localparam logic [4:0] ST_IX   = 5'd16;
    localparam logic [4:0] ST_RD   = 5'd17;
    localparam logic [4:0] ST_CK   = 5'd18;

    // Configuration registers.
    logic [15:0]        r_length;
    logic [15:0]        r_width;
    logic signed [23:0] r_origin_x;
    logic signed [23:0] r_origin_y;
    logic [31:0]        r_cpm;
    logic [12:0]        r_columns;
    logic [12:0]        r_rows;

    // Control state.
    logic [4:0]    r_state;
    logic          r_loaded;
    logic          r_valid;
    logic          r_hit;
    logic [1:0]    r_cause;
    logic [CW-1:0] r_cnt;
    logic [1:0]    r_k;

    // Datapath registers.
    logic signed [23:0] r_px;
    logic signed [23:0] r_py;
    logic signed [15:0] r_z;
    logic signed [67:0] r_prod;
    logic signed [31:0] r_cos;
    logic signed [32:0] r_sin;
    logic [RW-1:0]      r_rs;
    logic [SQ:0]        r_rem;
    logic [SQ-1:0]      r_root;
    logic signed [47:0] r_a;
    logic signed [47:0] r_b;
    logic signed [47:0] r_c;
    logic signed [47:0] r_d;
    logic [56:0]        r_magx;
    logic [56:0]        r_magy;
    logic               r_negx;
    logic               r_negy;
    logic [31:0]        r_lo_hi;
    logic signed [33:0] r_col;
    logic [12:0]        r_row;
    logic signed [7:0]  r_rdata;

    // Map memory and its port controls.
    logic [7:0]    mem [MAP_CELLS];
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;

    // Combinational helpers.
    logic signed [33:0] m_a;
    logic signed [33:0] m_b;
    logic signed [67:0] w_prod;
    logic [30:0]        w_rad;
    logic [63:0]        w_rs_wide;
    logic [SQ+16:0]     w_root_wide;
    logic [16:0]        w_root15;
    logic [SQ+2:0]      w_rem_in;
    logic [SQ+2:0]      w_trial;
    logic signed [57:0] w_base_x;
    logic signed [57:0] w_base_y;
    logic signed [57:0] w_x;
    logic signed [57:0] w_y;
    logic [57:0]        w_cell_sum;
    logic [32:0]        w_cell_mag;
    logic signed [33:0] w_cell;
    logic               w_outside;
    logic [25:0]        w_idx;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_valid;
    assign o_hit       = r_hit;
    assign o_hit_cause = r_cause;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length   <= 16'd1024;
            r_width    <= 16'd1024;
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_cpm      <= 32'd1310720;
            r_columns  <= 13'd256;
            r_rows     <= 13'd256;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                fgcc_pkg::REG_LENGTH:   r_length   <= i_cfg_data[15:0];
                fgcc_pkg::REG_WIDTH:    r_width    <= i_cfg_data[15:0];
                fgcc_pkg::REG_ORIGIN_X: r_origin_x <= i_cfg_data[23:0];
                fgcc_pkg::REG_ORIGIN_Y: r_origin_y <= i_cfg_data[23:0];
                fgcc_pkg::REG_CPM:      r_cpm      <= i_cfg_data;
                fgcc_pkg::REG_COLUMNS:  r_columns  <= i_cfg_data[12:0];
                fgcc_pkg::REG_ROWS:     r_rows     <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Shared multiplier: the operands follow the step, the product is registered.
    always_comb begin
        case (r_state)
            ST_ZZ: begin
                m_a = 34'(r_z);
                m_b = 34'(r_z);
            end
            ST_SIN: begin
                m_a = 34'(r_z);
                m_b = $signed({17'b0, w_root15});
            end
            ST_PA: begin
                m_a = 34'(r_cos);
                m_b = $signed({18'b0, r_length});
            end
            ST_PB: begin
                m_a = 34'(r_sin);
                m_b = $signed({18'b0, r_width});
            end
            ST_PC: begin
                m_a = 34'(r_sin);
                m_b = $signed({18'b0, r_length});
            end
            ST_PD: begin
                m_a = 34'(r_cos);
                m_b = $signed({18'b0, r_width});
            end
            ST_LX: begin
                m_a = $signed({2'b0, r_magx[31:0]});
                m_b = $signed({2'b0, r_cpm});
            end
            ST_HX: begin
                m_a = $signed({9'b0, r_magx[56:32]});
                m_b = $signed({2'b0, r_cpm});
            end
            ST_FX: begin
                m_a = $signed({2'b0, r_magy[31:0]});
                m_b = $signed({2'b0, r_cpm});
            end
            ST_HY: begin
                m_a = $signed({9'b0, r_magy[56:32]});
                m_b = $signed({2'b0, r_cpm});
            end
            ST_IX: begin
                m_a = $signed({21'b0, r_row});
                m_b = $signed({21'b0, r_columns});
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign w_prod = m_a * m_b;

    // Radicand rescaled for the root, and the root brought back to Q15.
    assign w_rad       = 31'(32'sd1073741824 - r_prod[31:0]);
    assign w_rs_wide   = {1'b0, w_rad, 32'b0} >> SHR;
    assign w_root_wide = {r_root, 17'b0} >> (SQ + 1);
    assign w_root15    = w_root_wide[16:0];

    // One restoring square root digit.
    assign w_rem_in = {r_rem, r_rs[RW-1:RW-2]};
    assign w_trial  = {1'b0, r_root, 2'b01};

    // Corner position relative to the grid origin, in 2^-31 / 1024 m.
    assign w_base_x = 58'(34'(r_px) - 34'(r_origin_x)) <<< 31;
    assign w_base_y = 58'(34'(r_py) - 34'(r_origin_y)) <<< 31;
    assign w_x = w_base_x + (r_k[1] ? 58'(r_a) : -58'(r_a))
                          - (r_k[0] ? 58'(r_b) : -58'(r_b));
    assign w_y = w_base_y + (r_k[1] ? 58'(r_c) : -58'(r_c))
                          + (r_k[0] ? 58'(r_d) : -58'(r_d));

    // Scaled cell coordinate from the two partial products, truncated to zero.
    assign w_cell_sum = 58'(r_prod[56:0]) + 58'(r_lo_hi);
    assign w_cell_mag = w_cell_sum[57:25];
    assign w_cell     = (r_state == ST_FX ? r_negx : r_negy)
                        ? -$signed({1'b0, w_cell_mag}) : $signed({1'b0, w_cell_mag});

    assign w_outside = (r_col < 34'sd0) || (r_col >= $signed({21'b0, r_columns}))
                    || (w_cell < 34'sd0) || (w_cell >= $signed({21'b0, r_rows}));
    assign w_idx = r_prod[25:0] + 26'(r_col[12:0]);

    // Memory port controls: writes come only from idle, reads only mid-check,
    // so the two never touch the same cycle.
    assign w_wr_en   = (r_state == ST_IDLE) && start && (i_cmd == fgcc_pkg::CMD_WRITE)
                    && (32'(i_cell_index) < 32'(MAP_CELLS));
    assign w_wr_addr = AW'(i_cell_index);
    assign w_rd_en   = (r_state == ST_RD) && (32'(w_idx) < 32'(MAP_CELLS));
    assign w_rd_addr = AW'(w_idx);

    // Map memory with a registered read.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= i_cell_value;
        end
        if (w_rd_en) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    // Product register.
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    // Sequencer and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_loaded <= 1'b0;
            r_valid  <= 1'b0;
            r_hit    <= 1'b0;
            r_cause  <= fgcc_pkg::CAUSE_CLEAR;
            r_cnt    <= '0;
            r_k      <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        if (i_cmd == fgcc_pkg::CMD_WRITE) begin
                            r_loaded <= 1'b1;
                        end else if (!r_loaded) begin
                            r_valid <= 1'b1;
                            r_hit   <= 1'b0;
                            r_cause <= fgcc_pkg::CAUSE_CLEAR;
                        end else begin
                            r_px    <= i_pose_x;
                            r_py    <= i_pose_y;
                            r_z     <= i_orient_z;
                            r_state <= ST_ZZ;
                        end
                    end
                end
                ST_ZZ: begin
                    r_state <= ST_SQI;
                end
                ST_SQI: begin
                    // Cosine and the root's radicand from z squared.
                    r_cos   <= 32'sd1073741824 - (r_prod[31:0] <<< 1);
                    r_rs    <= w_rs_wide[RW-1:0];
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    if (w_rem_in >= w_trial) begin
                        r_rem  <= (SQ + 1)'(w_rem_in - w_trial);
                        r_root <= {r_root[SQ-2:0], 1'b1};
                    end else begin
                        r_rem  <= (SQ + 1)'(w_rem_in);
                        r_root <= {r_root[SQ-2:0], 1'b0};
                    end
                    r_rs  <= r_rs << 2;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(SQ - 1)) begin
                        r_state <= ST_SIN;
                    end
                end
                ST_SIN: begin
                    r_state <= ST_PA;
                end
                ST_PA: begin
                    r_sin   <= r_prod[32:0] <<< 1;
                    r_state <= ST_PB;
                end
                ST_PB: begin
                    r_a     <= r_prod[47:0];
                    r_state <= ST_PC;
                end
                ST_PC: begin
                    r_b     <= r_prod[47:0];
                    r_state <= ST_PD;
                end
                ST_PD: begin
                    r_c     <= r_prod[47:0];
                    r_state <= ST_PE;
                end
                ST_PE: begin
                    r_d     <= r_prod[47:0];
                    r_k     <= '0;
                    r_state <= ST_CRN;
                end
                ST_CRN: begin
                    // Split the corner offset into sign and magnitude.
                    r_negx  <= w_x[57];
                    r_negy  <= w_y[57];
                    r_magx  <= w_x[57] ? 57'(-w_x) : w_x[56:0];
                    r_magy  <= w_y[57] ? 57'(-w_y) : w_y[56:0];
                    r_state <= ST_LX;
                end
                ST_LX: begin
                    r_state <= ST_HX;
                end
                ST_HX: begin
                    r_lo_hi <= r_prod[63:32];
                    r_state <= ST_FX;
                end
                ST_FX: begin
                    r_col   <= w_cell;
                    r_state <= ST_HY;
                end
                ST_HY: begin
                    r_lo_hi <= r_prod[63:32];
                    r_state <= ST_FY;
                end
                ST_FY: begin
                    if (w_outside) begin
                        r_valid <= 1'b1;
                        r_hit   <= 1'b1;
                        r_cause <= fgcc_pkg::CAUSE_OUTSIDE;
                        r_state <= ST_IDLE;
                    end else begin
                        r_row   <= w_cell[12:0];
                        r_state <= ST_IX;
                    end
                end
                ST_IX: begin
                    r_state <= ST_RD;
                end
                ST_RD: begin
                    if (!w_rd_en) begin
                        r_valid <= 1'b1;
                        r_hit   <= 1'b1;
                        r_cause <= fgcc_pkg::CAUSE_OUTSIDE;
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_CK;
                    end
                end
                ST_CK: begin
                    if (r_rdata >= fgcc_pkg::OCCUPIED_LIMIT) begin
                        r_valid <= 1'b1;
                        r_hit   <= 1'b1;
                        r_cause <= fgcc_pkg::CAUSE_OCCUPIED;
                        r_state <= ST_IDLE;
                    end else if (r_k == 2'd3) begin
                        r_valid <= 1'b1;
                        r_hit   <= 1'b0;
                        r_cause <= fgcc_pkg::CAUSE_CLEAR;
                        r_state <= ST_IDLE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= ST_CRN;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // The hit flag agrees with the cause on every result word.
    `FGCC_ASSERT_NOW(a_hit_cause, o_valid, o_hit == (o_hit_cause != fgcc_pkg::CAUSE_CLEAR), "hit and cause disagree")
    // A result word is shown only once the sequencer is back in idle.
    `FGCC_ASSERT_NOW(a_valid_idle, o_valid, !busy, "result shown while busy")
    // A cell write never produces a result word.
    `FGCC_ASSERT_NEXT(a_write_silent, start && !busy && (i_cmd == fgcc_pkg::CMD_WRITE), !o_valid, "cell write gave a result")
    // A check with no map loaded answers clear in the next cycle.
    `FGCC_ASSERT_NEXT(a_unloaded_clear, start && !busy && (i_cmd == fgcc_pkg::CMD_CHECK) && !r_loaded, o_valid && !o_hit, "unloaded check not clear")

endmodule
